FILE: rtl/cbf_pkg.sv
// Shared types and constants of the counting Bloom filter core.
package cbf_pkg;

	// Operation codes carried in the input tuser field.
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	// Width of the probe count register and its value after reset.
	localparam int         CFG_W             = 5;
	localparam logic [4:0] PROBE_COUNT_RESET = 5'd4;

	// Counter width and saturation limit.
	localparam int         CTR_W       = 8;
	localparam logic [7:0] COUNTER_MAX = 8'd255;

	// Width of each half of the key hash.
	localparam int HASH_W = 64;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_READ,
		ST_UPDATE,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/counting_bloom_filter.sv
// Counting Bloom filter core: double-hashed probes into a RAM of saturating counters.
//
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata: hash_first[63:0], hash_second[127:64];
//                                           tuser: kind[1:0]
// m_axis    out  m_axis_tvalid/tready       tdata: present[0], zero padding [7:1]
// cfg       in   cfg_valid/cfg_ready        cfg_data: probe_count[4:0]
//
// After its accepting beat an item makes n probes, where n is the probe count limited to
// MAX_PROBES, and its result then enters the output register; the next beat is taken only
// after that, so one item is worked on at a time. Each probe is one read of the counter
// RAM and, for inserts and deletes, one write-back, and these probes set the pace. When
// TABLE_DEPTH is not a power of two, both hash halves are first reduced modulo the depth
// by a byte-wise fold against constant weights followed by a reciprocal multiplication.
// Queries stop at the first zero counter; an unused kind or a zero probe count makes no probe.
// After reset the counter RAM is cleared one entry per cycle, and no input beat is taken
// until that pass is over. A stalled output holds its result while the next item is
// accepted and worked on; only that item's hand-over waits.
module counting_bloom_filter #(
	parameter int TABLE_DEPTH = 4096,
	parameter int MAX_PROBES  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Input beats: tdata holds hash_first (bits 63:0) then hash_second (bits 127:64).
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [2*cbf_pkg::HASH_W-1:0] s_axis_tdata,
	// tuser holds kind (bits 1:0).
	input  logic [1:0]                s_axis_tuser,
	// Result beats: tdata holds present (bit 0), bits 7:1 are zero.
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [7:0]                m_axis_tdata,
	// Probe count register writes.
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [cbf_pkg::CFG_W-1:0] cfg_data
);

	import cbf_pkg::*;

	localparam int ADDR_W  = $clog2(TABLE_DEPTH);
	localparam int PROBE_W = $clog2(MAX_PROBES + 1);
	localparam int CNT_W   = (PROBE_W > CFG_W) ? PROBE_W : CFG_W;

	localparam logic [ADDR_W:0]   DEPTH_C   = (ADDR_W + 1)'(TABLE_DEPTH);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
	localparam bit                IS_POW2   = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
	localparam logic [CNT_W-1:0]  MAX_N     = CNT_W'(MAX_PROBES);

	// 2^64 modulo the depth: what is lost from the residue when the 64-bit probe sum wraps.
	localparam logic [HASH_W-1:0] HASH_MAX  = {HASH_W{1'b1}};
	localparam logic [HASH_W-1:0] WRAP_64   =
		((HASH_MAX % HASH_W'(TABLE_DEPTH)) + HASH_W'(1)) % HASH_W'(TABLE_DEPTH);
	localparam logic [ADDR_W-1:0] WRAP_RES  = WRAP_64[ADDR_W-1:0];

	// Hash reduction: eight bytes weighted by 2^(8k) mod depth sum to a value that fits in
	// FOLD_W bits, and the remainder of that fold comes from a reciprocal multiplication
	// that is exact for every fold value.
	localparam int                FOLD_W      = ADDR_W + 11;
	localparam int                QUO_W       = FOLD_W - ADDR_W + 1;
	localparam int                PROD_W      = 2 * FOLD_W + 1;
	localparam int                RECIP_SHIFT = FOLD_W + ADDR_W;
	localparam logic [HASH_W-1:0] ONE_64      = HASH_W'(1);
	localparam logic [HASH_W-1:0] DEPTH_64    = HASH_W'(TABLE_DEPTH);
	localparam logic [FOLD_W:0]   RECIP       =
		(FOLD_W + 1)'(((ONE_64 << RECIP_SHIFT) + DEPTH_64 - ONE_64) / DEPTH_64);

	state_t state_q, state_d;

	// Control registers.
	logic [ADDR_W-1:0] clr_addr_q;
	logic [CFG_W-1:0]  probe_count_q;
	logic              out_valid_q;

	// Per-item working registers.
	logic [1:0]        kind_q;
	logic [HASH_W-1:0] hsum_q;
	logic [HASH_W-1:0] h2_q;
	logic [ADDR_W-1:0] res_q;
	logic [ADDR_W-1:0] stride_res_q;
	logic [1:0]        red_step_q;
	logic [FOLD_W-1:0] fold_s1;
	logic [FOLD_W-1:0] fold_s2;
	logic [QUO_W-1:0]  quo_s2;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  i_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic              present_q;
	logic              out_present_q;

	// Handshake and RAM control.
	logic              in_fire;
	logic              out_load;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CTR_W-1:0]  ram_wdata;
	logic [CTR_W-1:0]  ram_rdata;

	// Combinational datapath.
	logic [CNT_W-1:0]  pc_ext;
	logic [CNT_W-1:0]  n_acc;
	logic              kind_valid;
	logic [ADDR_W:0]   sum_w;
	logic [ADDR_W-1:0] red_lo;
	logic [HASH_W:0]   hsum_w;
	logic [ADDR_W:0]   unwrap_w;
	logic [ADDR_W-1:0] res_next;
	logic [HASH_W-1:0] red_src;
	logic [FOLD_W-1:0] byte_term [8];
	logic [FOLD_W-1:0] fold_w;
	logic [PROD_W-1:0] recip_prod;
	logic [QUO_W-1:0]  quo_w;
	logic [FOLD_W-1:0] rem_w;
	logic [CTR_W-1:0]  ctr_inc;
	logic [CTR_W-1:0]  ctr_dec;
	logic              ctr_zero;
	logic              probe_last;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	// Probe count limited to what the design supports.
	assign pc_ext     = CNT_W'(probe_count_q);
	assign n_acc      = (pc_ext > MAX_N) ? MAX_N : pc_ext;
	assign kind_valid = (s_axis_tuser == KIND_INSERT) || (s_axis_tuser == KIND_DELETE) ||
	                    (s_axis_tuser == KIND_QUERY);

	// Next probe residue: add the stride residue modulo the depth, then take away the
	// wrap residue whenever the full 64-bit probe sum overflows.
	assign sum_w    = {1'b0, res_q} + {1'b0, stride_res_q};
	assign red_lo   = (sum_w >= DEPTH_C) ? ADDR_W'(sum_w - DEPTH_C) : sum_w[ADDR_W-1:0];
	assign hsum_w   = {1'b0, hsum_q} + {1'b0, h2_q};
	assign unwrap_w = {1'b0, red_lo} + DEPTH_C - {1'b0, WRAP_RES};

	always_comb begin
		if (!hsum_w[HASH_W]) begin
			res_next = red_lo;
		end else if (red_lo >= WRAP_RES) begin
			res_next = red_lo - WRAP_RES;
		end else begin
			res_next = unwrap_w[ADDR_W-1:0];
		end
	end

	// Reduction of the hash halves: the base is folded in the first step, the stride in
	// the second, and each fold then passes through the quotient and remainder stages.
	assign red_src = (red_step_q == 2'd0) ? hsum_q : h2_q;

	for (genvar g = 0; g < 8; g++) begin : g_fold
		localparam logic [FOLD_W-1:0] WEIGHT = FOLD_W'((ONE_64 << (8 * g)) % DEPTH_64);
		assign byte_term[g] = FOLD_W'(red_src[8*g +: 8]) * WEIGHT;
	end

	always_comb begin
		fold_w = '0;
		for (int k = 0; k < 8; k++) begin
			fold_w = fold_w + byte_term[k];
		end
	end

	assign recip_prod = PROD_W'(fold_s1) * PROD_W'(RECIP);
	assign quo_w      = recip_prod[RECIP_SHIFT +: QUO_W];
	assign rem_w      = fold_s2 - FOLD_W'(quo_s2) * FOLD_W'(TABLE_DEPTH);

	// Counter arithmetic on the word just read back.
	assign ctr_zero   = (ram_rdata == '0);
	assign ctr_inc    = (ram_rdata == COUNTER_MAX) ? ram_rdata : ram_rdata + CTR_W'(1);
	assign ctr_dec    = ctr_zero ? ram_rdata : ram_rdata - CTR_W'(1);
	assign probe_last = (i_q == n_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_fire) begin
					if (!kind_valid || n_acc == '0) begin
						state_d = ST_DONE;
					end else if (IS_POW2) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_REDUCE;
					end
				end
			end
			ST_REDUCE: begin
				if (red_step_q == 2'd3) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if ((kind_q == KIND_QUERY && ctr_zero) || probe_last) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// State-dependent outputs and RAM write port.
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
		ram_we        = (state_q == ST_CLEAR) ||
		                ((state_q == ST_UPDATE) &&
		                 (kind_q == KIND_INSERT || kind_q == KIND_DELETE));
		ram_waddr     = (state_q == ST_CLEAR) ? clr_addr_q : wr_addr_q;
		if (state_q == ST_CLEAR) begin
			ram_wdata = '0;
		end else if (kind_q == KIND_INSERT) begin
			ram_wdata = ctr_inc;
		end else begin
			ram_wdata = ctr_dec;
		end
	end

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_present_q};

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_addr_q    <= '0;
			probe_count_q <= PROBE_COUNT_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (cfg_valid && cfg_ready) begin
				probe_count_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Per-item datapath registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q     <= s_axis_tuser;
			hsum_q     <= s_axis_tdata[HASH_W-1:0];
			h2_q       <= s_axis_tdata[2*HASH_W-1:HASH_W];
			n_q        <= n_acc;
			i_q        <= '0;
			red_step_q <= '0;
			present_q  <= (s_axis_tuser == KIND_QUERY);
			if (IS_POW2) begin
				res_q        <= s_axis_tdata[ADDR_W-1:0];
				stride_res_q <= s_axis_tdata[HASH_W+ADDR_W-1:HASH_W];
			end else begin
				res_q        <= '0;
				stride_res_q <= '0;
			end
		end
		if (state_q == ST_REDUCE) begin
			red_step_q <= red_step_q + 2'd1;
			fold_s1    <= fold_w;
			fold_s2    <= fold_s1;
			quo_s2     <= quo_w;
			if (red_step_q == 2'd2) begin
				res_q <= rem_w[ADDR_W-1:0];
			end
			if (red_step_q == 2'd3) begin
				stride_res_q <= rem_w[ADDR_W-1:0];
			end
		end
		if (state_q == ST_READ) begin
			wr_addr_q <= res_q;
			res_q     <= res_next;
			hsum_q    <= hsum_w[HASH_W-1:0];
			i_q       <= i_q + CNT_W'(1);
		end
		if (state_q == ST_UPDATE && kind_q == KIND_QUERY && ctr_zero) begin
			present_q <= 1'b0;
		end
		if (out_load) begin
			out_present_q <= present_q;
		end
	end

	cbf_ram #(
		.WIDTH (CTR_W),
		.DEPTH (TABLE_DEPTH)
	) u_ctr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (res_q),
		.rdata (ram_rdata)
	);

	// Read data is only used in the cycle after its read was issued.
	a_update_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> ($past(state_q) == ST_READ))
		else $error("counter update without a preceding read");

	// The counter RAM is only written by the clearing pass or by insert and delete.
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR ||
		            (state_q == ST_UPDATE && (kind_q == KIND_INSERT || kind_q == KIND_DELETE))))
		else $error("counter RAM written outside clear or update");

	// No probe is issued beyond the item's probe count.
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_UPDATE) |-> (i_q <= n_q))
		else $error("probe counter beyond probe count");

	// Residues used as RAM addresses stay below the table depth.
	a_residue_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> ({1'b0, res_q} < DEPTH_C))
		else $error("probe residue outside the table");

	// A waiting result is never overwritten by the next item.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_present_q)))
		else $error("stalled result overwritten");

endmodule

FILE: rtl/cbf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: tb/counting_bloom_filter_tb.sv
// Self-checking testbench for the counting Bloom filter core.
module counting_bloom_filter_tb;
	import cbf_pkg::*;

	localparam int TABLE_DEPTH = 4096;
	localparam int MAX_PROBES  = 16;

	// The package names three operations; the fourth encoding must leave the counters alone and answer not present.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ALT_A    = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [63:0] ALT_5    = 64'h5555_5555_5555_5555;

	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 170;
	localparam int POOL_SIZE   = 16;
	localparam int HAMMER_LEN  = 18;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [2*HASH_W-1:0]  s_axis_tdata;
	logic [1:0]           s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [7:0]           m_axis_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data;

	counting_bloom_filter #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.MAX_PROBES (MAX_PROBES)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Our own image of the counter RAM and of the probe count register.
	logic [CTR_W-1:0] counter_image [TABLE_DEPTH];
	logic [CFG_W-1:0] probe_setting;

	// Presence answers still owed by the core, oldest first.
	bit present_owed_q [$];

	// Cleared for the closing phase so that the run ends at full rate on both sides.
	bit idling_on;

	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned n_insert, n_delete, n_query, n_unused, n_found;
	int unsigned n_saturated, n_floored, n_settings;

	// Keys that are inserted, looked up and deleted over and over. The first few have a
	// stride that is a multiple of the table depth, so every probe lands on one counter and
	// the counter quickly reaches either end of its range.
	logic [HASH_W-1:0] key_base   [POOL_SIZE];
	logic [HASH_W-1:0] key_stride [POOL_SIZE];

	// One row of the directed part: either a register write or an input beat. Where the
	// answer is obvious it is typed in; otherwise it comes from the filter image.
	typedef struct {
		bit                is_cfg;
		logic [CFG_W-1:0]  setting;
		logic [1:0]        kind;
		logic [HASH_W-1:0] base;
		logic [HASH_W-1:0] stride;
		bit                typed;
		bit                present;
	} step_row_t;

	localparam int N_ROWS = 26;

	step_row_t directed_rows [N_ROWS] = '{
		// Fresh table: nothing can be present, and deleting from zero must leave zero.
		'{1'b0, 5'd0,  KIND_QUERY,  64'd0,    64'd0,    1'b1, 1'b0},
		'{1'b0, 5'd0,  KIND_DELETE, ALL_ONES, ALL_ONES, 1'b1, 1'b0},
		'{1'b0, 5'd0,  KIND_INSERT, 64'd0,    64'd0,    1'b1, 1'b0},
		'{1'b0, 5'd0,  KIND_QUERY,  64'd0,    64'd0,    1'b0, 1'b0},
		// Base of all ones with stride one wraps round the 64-bit sum to slot zero.
		'{1'b0, 5'd0,  KIND_QUERY,  ALL_ONES, 64'd1,    1'b0, 1'b0},
		'{1'b0, 5'd0,  KIND_INSERT, ALL_ONES, ALL_ONES, 1'b1, 1'b0},
		'{1'b0, 5'd0,  KIND_QUERY,  ALL_ONES, ALL_ONES, 1'b0, 1'b0},
		'{1'b0, 5'd0,  KIND_UNUSED, ALL_ONES, ALL_ONES, 1'b1, 1'b0},
		'{1'b0, 5'd0,  KIND_DELETE, 64'd0,    64'd0,    1'b1, 1'b0},
		'{1'b0, 5'd0,  KIND_QUERY,  64'd0,    64'd0,    1'b0, 1'b0},
		// With no probes at all a lookup finds nothing to refute it.
		'{1'b1, 5'd0,  KIND_INSERT, 64'd0,    64'd0,    1'b0, 1'b0},
		'{1'b0, 5'd0,  KIND_QUERY,  64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
			1'b1, 1'b1},
		'{1'b0, 5'd0,  KIND_INSERT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
			1'b1, 1'b0},
		'{1'b0, 5'd0,  KIND_DELETE, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
			1'b1, 1'b0},
		// Register above the probe limit: the core must clamp it.
		'{1'b1, 5'd31, KIND_INSERT, 64'd0,    64'd0,    1'b0, 1'b0},
		'{1'b0, 5'd0,  KIND_INSERT, 64'd5,    64'h1000, 1'b1, 1'b0},
		'{1'b0, 5'd0,  KIND_QUERY,  64'd5,    64'h1000, 1'b0, 1'b0},
		'{1'b0, 5'd0,  KIND_QUERY,  ALT_A,    ALT_5,    1'b0, 1'b0},
		'{1'b1, 5'd1,  KIND_INSERT, 64'd0,    64'd0,    1'b0, 1'b0},
		'{1'b0, 5'd0,  KIND_INSERT, ALT_A,    ALT_5,    1'b1, 1'b0},
		'{1'b0, 5'd0,  KIND_QUERY,  ALT_A,    ALT_5,    1'b0, 1'b0},
		'{1'b0, 5'd0,  KIND_QUERY,  ALT_5,    ALT_A,    1'b0, 1'b0},
		'{1'b1, 5'd16, KIND_INSERT, 64'd0,    64'd0,    1'b0, 1'b0},
		'{1'b0, 5'd0,  KIND_INSERT, 64'h8000_0000_0000_0FFF, 64'h7FFF_FFFF_FFFF_F001,
			1'b1, 1'b0},
		'{1'b0, 5'd0,  KIND_QUERY,  64'h8000_0000_0000_0FFF, 64'h7FFF_FFFF_FFFF_F001,
			1'b0, 1'b0},
		'{1'b1, 5'd4,  KIND_INSERT, 64'd0,    64'd0,    1'b0, 1'b0}
	};

	// Probe counts for the random phases: mid-range counts mixed with the extremes 0, 1, 16, 17 and 31.
	logic [CFG_W-1:0] phase_settings [PHASES] = '{
		5'd3, 5'd1, 5'd16, 5'd31, 5'd0, 5'd17, 5'd8, 5'd2, 5'd12, 5'd4
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous ceiling: it covers the run plus the clearing pass even with every beat at
	// sixteen probes and the longest stalls on both sides.
	initial begin
		#5_000_000;
		$display("counting_bloom_filter verification failed");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Applies one operation to the filter image and returns the presence answer.
	function automatic bit bloom_apply(input logic [1:0] kind, input logic [HASH_W-1:0] base,
			input logic [HASH_W-1:0] stride);
		int unsigned       probes;
		int unsigned       i;
		int unsigned       slot;
		logic [HASH_W-1:0] sum;
		bit                found;
		probes = (probe_setting > MAX_PROBES) ? MAX_PROBES : probe_setting;
		found = (kind == KIND_QUERY);
		for (i = 0; i < probes; i++) begin
			sum  = base + HASH_W'(i) * stride;
			slot = int'(sum % HASH_W'(TABLE_DEPTH));
			case (kind)
				KIND_INSERT: begin
					if (counter_image[slot] == COUNTER_MAX)
						n_saturated++;
					else
						counter_image[slot] = counter_image[slot] + 1'b1;
				end
				KIND_DELETE: begin
					if (counter_image[slot] == '0)
						n_floored++;
					else
						counter_image[slot] = counter_image[slot] - 1'b1;
				end
				KIND_QUERY: begin
					// The first empty counter settles the answer.
					if (found && counter_image[slot] == '0)
						found = 1'b0;
				end
				default: ;
			endcase
		end
		return found;
	endfunction

	// Offers one beat, holding tvalid across back-to-back beats, and books the answer
	// owed for it at the edge where it is taken.
	task automatic send_beat(input logic [1:0] kind, input logic [HASH_W-1:0] base,
			input logic [HASH_W-1:0] stride, input bit typed, input bit typed_present);
		bit predicted;
		if (idling_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {stride, base};
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predicted = bloom_apply(kind, base, stride);
		present_owed_q.push_back(typed ? typed_present : predicted);
		case (kind)
			KIND_INSERT: n_insert++;
			KIND_DELETE: n_delete++;
			KIND_QUERY: begin
				n_query++;
				if (predicted)
					n_found++;
			end
			default: n_unused++;
		endcase
	endtask

	// Stops offering beats and waits until the core has handed over every answer.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (present_owed_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// The register is only written with the core idle.
	task automatic write_probe_count(input logic [CFG_W-1:0] setting);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= setting;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		probe_setting = setting;
		n_settings++;
	endtask

	task automatic renew_key(input int idx);
		key_base[idx]   = {$urandom(), $urandom()};
		key_stride[idx] = {$urandom(), $urandom()};
		// Low slots keep a stride that is a whole multiple of the depth.
		if (idx < 4)
			key_stride[idx] = key_stride[idx] & ~HASH_W'(TABLE_DEPTH - 1);
	endtask

	// Receiver side: random bursts of back-pressure while idling is on.
	initial begin
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idling_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Every result beat is matched against the oldest answer still owed; the padding
	// above the presence bit must stay zero.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (present_owed_q.size() == 0) begin
				report_mismatch($sformatf("result beat %0d arrived with nothing owed, tdata %h",
					results_seen, m_axis_tdata));
			end else begin
				if (m_axis_tdata !== {7'd0, present_owed_q[0]})
					report_mismatch($sformatf("result beat %0d: tdata %h, wanted present %0d",
						results_seen, m_axis_tdata, present_owed_q[0]));
				void'(present_owed_q.pop_front());
			end
		end
	end

	initial begin
		int          row;
		int          phase;
		int          n;
		int          idx;
		int unsigned pick;
		logic [1:0]  kind;
		logic [HASH_W-1:0] base;
		logic [HASH_W-1:0] stride;

		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= KIND_INSERT;
		cfg_valid     <= 1'b0;
		cfg_data      <= PROBE_COUNT_RESET;
		idling_on     = 1'b1;
		probe_setting = PROBE_COUNT_RESET;
		mismatches    = 0;
		results_seen  = 0;
		foreach (counter_image[k])
			counter_image[k] = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The core clears its RAM after reset; tready holds us off meanwhile.
		for (row = 0; row < N_ROWS; row++) begin
			if (directed_rows[row].is_cfg)
				write_probe_count(directed_rows[row].setting);
			else
				send_beat(directed_rows[row].kind, directed_rows[row].base,
					directed_rows[row].stride, directed_rows[row].typed,
					directed_rows[row].present);
		end

		for (idx = 0; idx < POOL_SIZE; idx++)
			renew_key(idx);

		// Random part: mostly operations on a small set of recurring keys, so that lookups
		// find their keys, deletes empty counters and shared slots interfere, with fresh
		// keys and the unused operation mixed in as noise.
		for (phase = 0; phase < PHASES; phase++) begin
			write_probe_count(phase_settings[phase]);
			if (phase == PHASES - 1)
				idling_on = 1'b0;
			for (n = 0; n < 4; n++)
				renew_key(4 + $urandom_range(0, POOL_SIZE - 5));

			// At the probe limit, drive one single-slot key to the top of the counter
			// range and back down past zero.
			if (phase_settings[phase] == MAX_PROBES) begin
				for (n = 0; n < HAMMER_LEN; n++)
					send_beat(KIND_INSERT, key_base[0], key_stride[0], 1'b0, 1'b0);
				send_beat(KIND_QUERY, key_base[0], key_stride[0], 1'b0, 1'b0);
				for (n = 0; n < HAMMER_LEN; n++)
					send_beat(KIND_DELETE, key_base[0], key_stride[0], 1'b0, 1'b0);
				send_beat(KIND_QUERY, key_base[0], key_stride[0], 1'b0, 1'b0);
			end

			for (n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					kind = KIND_INSERT;
				else if (pick < 60)
					kind = KIND_DELETE;
				else if (pick < 95)
					kind = KIND_QUERY;
				else
					kind = KIND_UNUSED;
				if ($urandom_range(0, 4) != 0) begin
					idx    = $urandom_range(0, POOL_SIZE - 1);
					base   = key_base[idx];
					stride = key_stride[idx];
				end else begin
					base   = {$urandom(), $urandom()};
					stride = {$urandom(), $urandom()};
				end
				send_beat(kind, base, stride, 1'b0, 1'b0);
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);

		$display("Covered %0d inserts, %0d deletes, %0d lookups and %0d unused beats over %0d probe settings.",
			n_insert, n_delete, n_query, n_unused, n_settings);
		$display("Lookups found %0d keys; %0d probes hit a full counter and %0d an empty one.",
			n_found, n_saturated, n_floored);
		if (mismatches == 0)
			$display("counting_bloom_filter verification clean");
		else
			$display("counting_bloom_filter verification failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/cbf_pkg.sv
rtl/cbf_ram.sv
rtl/counting_bloom_filter.sv
tb/counting_bloom_filter_tb.sv
